@@ rtl/core/spq_pkg.sv @@
package spq_pkg;

    // One stored queue entry: Q16.16 key, source list number and position.
    typedef struct packed {
        logic signed [31:0] key;
        logic [3:0]         list;
        logic [15:0]        index;
    } entry_t;

    // Request action codes.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic   insert_en;
        logic   pop_en;
        entry_t data;
    } cell_cmd_t;

endpackage

@@ rtl/core/spq_cmd_if.sv @@
interface spq_cmd_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] key;
    logic [3:0]         source_list;
    logic [15:0]        source_index;

    modport source (
        output valid, action, key, source_list, source_index,
        input  ready
    );

    modport sink (
        input  valid, action, key, source_list, source_index,
        output ready
    );
endinterface

@@ rtl/core/spq_rsp_if.sv @@
interface spq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic [3:0]         out_list;
    logic [15:0]        out_index;
    logic [4:0]         occupancy;

    modport source (
        output valid, status, out_key, out_list, out_index, occupancy,
        input  ready
    );

    modport sink (
        input  valid, status, out_key, out_list, out_index, occupancy,
        output ready
    );
endinterface

@@ rtl/core/spq_cell.sv @@
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               prev_shift,
    input  spq_pkg::entry_t    prev_entry,
    input  spq_pkg::entry_t    next_entry,
    output logic               shift,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            take;

    // The new key moves this entry down when it is strictly smaller.
    assign shift = occupied && (cmd.data.key < entry_reg.key);

    // An empty cell or a displaced one takes either its upper neighbor or the new entry.
    assign take = shift || !occupied;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert_en && take)
        begin
            entry_next = prev_shift ? prev_entry : cmd.data;
        end
        else if (cmd.pop_en)
        begin
            entry_next = next_entry;
        end
    end

    // Entry storage holds payload only and is not reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/core/sorted_priority_queue_top.sv @@
// Sorted priority queue built as a chain of compare-and-shift cells.
// The response to an accepted request is registered and shows in the next cycle.
// Throughput: one request per cycle; every cell compares against the broadcast key
// and shifts one place in that same cycle. A new request enters while the response
// register is empty or while its waiting response is taken in that same cycle.
// Reset clears the entry count and the response valid; entry storage is not cleared.
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    spq_cmd_if.sink         cmd,
    spq_rsp_if.source       rsp
);

    localparam int CountW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        spq_pkg::status_t   status;
        spq_pkg::entry_t    data;
        logic [4:0]         occupancy;
    } rsp_t;

    logic [CountW-1:0]   count_reg;
    logic [CountW-1:0]   count_next;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                accept;
    logic                is_full;
    logic                is_empty;
    spq_pkg::cell_cmd_t  cell_cmd;
    spq_pkg::entry_t     entries [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] shifts;
    logic [QUEUE_DEPTH-1:0] occupied;

    // Request handshake: the response register frees up when it is taken.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign is_full  = (count_reg == CountW'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Operation broadcast to the cells.
    always_comb
    begin
        cell_cmd.insert_en  = accept && (cmd.action == spq_pkg::ACT_INSERT) && !is_full;
        cell_cmd.pop_en     = accept && (cmd.action == spq_pkg::ACT_POP) && !is_empty;
        cell_cmd.data.key   = cmd.key;
        cell_cmd.data.list  = cmd.source_list;
        cell_cmd.data.index = cmd.source_index;
    end

    // Cell chain: cell zero holds the smallest key.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t prev_entry;
        spq_pkg::entry_t next_entry;
        logic            prev_shift;

        assign occupied[i] = (count_reg > CountW'(i));

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
            assign prev_shift = 1'b0;
        end
        else
        begin : g_mid
            assign prev_entry = entries[i-1];
            assign prev_shift = shifts[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_entry = '0;
        end
        else
        begin : g_inner
            assign next_entry = entries[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .occupied   (occupied[i]),
            .prev_shift (prev_shift),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .shift      (shifts[i]),
            .entry      (entries[i])
        );
    end

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (cell_cmd.insert_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cell_cmd.pop_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Response contents for the accepted request.
    always_comb
    begin
        rsp_next.status    = spq_pkg::ST_OK;
        rsp_next.data      = '0;
        rsp_next.occupancy = 5'(count_next);
        if (cmd.action == spq_pkg::ACT_INSERT)
        begin
            if (is_full)
            begin
                rsp_next.status = spq_pkg::ST_FULL;
            end
        end
        else if (is_empty)
        begin
            rsp_next.status = spq_pkg::ST_EMPTY;
        end
        else
        begin
            rsp_next.data = entries[0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_reg.status;
    assign rsp.out_key   = rsp_reg.data.key;
    assign rsp.out_list  = rsp_reg.data.list;
    assign rsp.out_index = rsp_reg.data.index;
    assign rsp.occupancy = rsp_reg.occupancy;

`ifndef SYNTHESIS
    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(QUEUE_DEPTH))
        else $error("entry count above capacity");

    // A pop on a non-empty queue lowers the count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.action == spq_pkg::ACT_POP && !is_empty)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower the entry count");

    // An insert into a full queue reports the drop.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.action == spq_pkg::ACT_INSERT && is_full)
        |=> (rsp_reg.status == spq_pkg::ST_FULL && count_reg == $past(count_reg)))
        else $error("full insert not dropped");

    // The two front cells stay in ascending key order.
    a_front_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CountW'(2)) |-> !(entries[1].key < entries[0].key))
        else $error("front entries out of order");
`endif

endmodule
